// ----- hw/rtl/dltq_pkg.sv -----
// ----------------------------------------------------------------------------
// Delta-list timer queue package
// Shared types, codes and constants of the timer queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dltq_pkg;

  localparam int ID_W     = 4;
  localparam int MS_W     = 32;
  localparam int SLOT_MAX = 16;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_TICK = 2'd2,
    OP_RSVD = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_DONE     = 2'd0,
    KIND_EXPIRED  = 2'd1,
    KIND_REJECTED = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]      operation;
    logic [ID_W-1:0] timer_id;
    logic [MS_W-1:0] timeout_ms;
    logic [MS_W-1:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] expired_id;
    logic            kick;
    logic            queue_empty;
    logic [MS_W-1:0] next_timeout_ms;
    logic            last;
  } out_item_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_WALK,
    CMD_INSERT,
    CMD_SEARCH,
    CMD_REMOVE,
    CMD_MERGE,
    CMD_DEL_MISS,
    CMD_TICK,
    CMD_EMIT
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e cmd;
    kind_e   kind;
    logic    last;
    logic    use_who;
  } dltq_cmd_t;

  typedef struct packed {
    op_e  op;
    logic add_reject;
    logic del_hit;
    logic walk_end;
    logic walk_hit;
    logic search_end;
    logic search_hit;
    logic tick_empty;
    logic tick_keep;
    logic out_free;
  } dltq_status_t;

endpackage

// ----- hw/rtl/dltq_if.sv -----
// ----------------------------------------------------------------------------
// Delta-list timer queue channels
// Valid/ready channels for request and result transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dltq_in_if;
  import dltq_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface dltq_out_if;
  import dltq_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/dltq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Delta-list timer queue controller
// Sequences add, delete and tick over the list datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dltq_ctrl
  import dltq_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  dltq_status_t status_i,
  output dltq_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ADD_WALK,
    ST_ADD_INSERT,
    ST_DEL_SEARCH,
    ST_DEL_REMOVE,
    ST_DEL_MERGE,
    ST_DEL_MISS,
    ST_TICK_STEP,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;
  logic   last_q, last_d;
  logic   use_who_q, use_who_d;

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    last_d    = last_q;
    use_who_d = use_who_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        last_d    = 1'b1;
        use_who_d = 1'b0;
        kind_d    = KIND_DONE;
        unique case (status_i.op)
          OP_ADD: begin
            if (status_i.add_reject) begin
              kind_d  = KIND_REJECTED;
              state_d = ST_EMIT;
            end else begin
              state_d = ST_ADD_WALK;
            end
          end
          OP_DEL: begin
            state_d = status_i.del_hit ? ST_DEL_SEARCH : ST_EMIT;
          end
          OP_TICK: begin
            state_d = ST_TICK_STEP;
          end
          default: begin
            kind_d  = KIND_REJECTED;
            state_d = ST_EMIT;
          end
        endcase
      end
      ST_ADD_WALK: begin
        if (status_i.walk_end || status_i.walk_hit) begin
          state_d = ST_ADD_INSERT;
        end
      end
      ST_ADD_INSERT: begin
        state_d = ST_EMIT;
      end
      ST_DEL_SEARCH: begin
        if (status_i.search_end) begin
          state_d = ST_DEL_MISS;
        end else if (status_i.search_hit) begin
          state_d = ST_DEL_REMOVE;
        end
      end
      ST_DEL_REMOVE: begin
        state_d = ST_DEL_MERGE;
      end
      ST_DEL_MERGE, ST_DEL_MISS: begin
        state_d = ST_EMIT;
      end
      ST_TICK_STEP: begin
        state_d = ST_EMIT;
        if (status_i.tick_empty || status_i.tick_keep) begin
          kind_d    = KIND_DONE;
          last_d    = 1'b1;
          use_who_d = 1'b0;
        end else begin
          kind_d    = KIND_EXPIRED;
          last_d    = 1'b0;
          use_who_d = 1'b1;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = last_q ? ST_IDLE : ST_TICK_STEP;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      kind_q    <= KIND_DONE;
      last_q    <= 1'b0;
      use_who_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      kind_q    <= kind_d;
      last_q    <= last_d;
      use_who_q <= use_who_d;
    end
  end

  always_comb begin
    cmd_o.kind    = kind_q;
    cmd_o.last    = last_q;
    cmd_o.use_who = use_who_q;
    unique case (state_q)
      ST_IDLE:       cmd_o.cmd = in_valid_i ? CMD_CAPTURE : CMD_NONE;
      ST_ADD_WALK:   cmd_o.cmd = CMD_WALK;
      ST_ADD_INSERT: cmd_o.cmd = CMD_INSERT;
      ST_DEL_SEARCH: cmd_o.cmd = CMD_SEARCH;
      ST_DEL_REMOVE: cmd_o.cmd = CMD_REMOVE;
      ST_DEL_MERGE:  cmd_o.cmd = CMD_MERGE;
      ST_DEL_MISS:   cmd_o.cmd = CMD_DEL_MISS;
      ST_TICK_STEP:  cmd_o.cmd = CMD_TICK;
      ST_EMIT:       cmd_o.cmd = CMD_EMIT;
      default:       cmd_o.cmd = CMD_NONE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  a_emit_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && status_i.out_free && last_q) |=> in_ready_o)
    else $error("controller did not return to idle after last result");

  a_walk_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD_WALK && status_i.walk_end) |=> (state_q == ST_ADD_INSERT))
    else $error("add walk ran past the list tail");

endmodule

// ----- hw/rtl/dltq_datapath.sv -----
// ----------------------------------------------------------------------------
// Delta-list timer queue datapath
// List registers, walk and search index, subtract/merge units, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dltq_datapath
  import dltq_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  in_item_t     in_item_i,
  input  logic         out_ready_i,
  input  dltq_cmd_t    cmd_i,
  output dltq_status_t status_o,
  output logic         out_valid_o,
  output out_item_t    out_item_o
);

  localparam int CntW = $clog2(SLOTS + 1);
  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [ID_W-1:0] slot_timer_q [SLOTS];
  logic [ID_W-1:0] slot_timer_d [SLOTS];
  logic [MS_W-1:0] slot_delta_q [SLOTS];
  logic [MS_W-1:0] slot_delta_d [SLOTS];
  logic [CntW-1:0] count_q, count_d;
  logic [SLOTS-1:0] active_q, active_d;

  op_e             op_q, op_d;
  logic [ID_W-1:0] id_q, id_d;
  logic [MS_W-1:0] rem_q, rem_d;
  logic [MS_W-1:0] elapsed_q, elapsed_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic [MS_W-1:0] carry_q, carry_d;
  logic [ID_W-1:0] who_q, who_d;
  logic            kick_q, kick_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_item_q, out_item_d;

  logic [IdxW-1:0] idx_w;
  logic [IdxW-1:0] pos_w;
  logic [IdxW-1:0] id_w;
  logic [IdxW-1:0] head_w;
  logic            id_ok;
  logic [MS_W-1:0] sel_delta;
  logic [ID_W-1:0] sel_timer;
  logic [MS_W:0]   merge_sum;
  logic            load;

  assign idx_w     = idx_q[IdxW-1:0];
  assign pos_w     = pos_q[IdxW-1:0];
  assign id_w      = id_q[IdxW-1:0];
  assign head_w    = slot_timer_q[0][IdxW-1:0];
  assign id_ok     = (int'(id_q) < SLOTS);
  assign sel_delta = slot_delta_q[idx_w];
  assign sel_timer = slot_timer_q[idx_w];
  assign merge_sum = {1'b0, sel_delta} + {1'b0, carry_q};
  assign load      = (cmd_i.cmd == CMD_EMIT) && status_o.out_free;

  always_comb begin
    status_o.op         = op_q;
    status_o.add_reject = !id_ok || active_q[id_w] || (rem_q == '0) || (rem_q == '1)
                          || (count_q >= CntW'(SLOTS));
    status_o.del_hit    = id_ok && active_q[id_w];
    status_o.walk_end   = (idx_q == count_q);
    status_o.walk_hit   = (rem_q < sel_delta);
    status_o.search_end = (idx_q == count_q);
    status_o.search_hit = (sel_timer == id_q);
    status_o.tick_empty = (count_q == '0);
    status_o.tick_keep  = (slot_delta_q[0] > elapsed_q);
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_comb begin
    slot_timer_d = slot_timer_q;
    slot_delta_d = slot_delta_q;
    count_d      = count_q;
    active_d     = active_q;
    op_d         = op_q;
    id_d         = id_q;
    rem_d        = rem_q;
    elapsed_d    = elapsed_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    carry_d      = carry_q;
    who_d        = who_q;
    kick_d       = kick_q;
    out_item_d   = out_item_q;
    out_valid_d  = out_ready_i ? 1'b0 : out_valid_q;

    case (cmd_i.cmd)
      CMD_CAPTURE: begin
        op_d      = op_e'(in_item_i.operation);
        id_d      = in_item_i.timer_id;
        rem_d     = in_item_i.timeout_ms;
        elapsed_d = in_item_i.elapsed_ms;
        idx_d     = '0;
        kick_d    = 1'b0;
      end
      CMD_WALK: begin
        if (idx_q == count_q) begin
          pos_d = count_q;
        end else if (rem_q < sel_delta) begin
          slot_delta_d[idx_w] = sel_delta - rem_q;
          pos_d               = idx_q;
        end else begin
          rem_d = rem_q - sel_delta;
          idx_d = idx_q + CntW'(1);
        end
      end
      CMD_INSERT: begin
        for (int j = 1; j < SLOTS; j++) begin
          if (CntW'(j) > pos_q) begin
            slot_timer_d[j] = slot_timer_q[j-1];
            slot_delta_d[j] = slot_delta_q[j-1];
          end
        end
        slot_timer_d[pos_w] = id_q;
        slot_delta_d[pos_w] = rem_q;
        count_d             = count_q + CntW'(1);
        active_d[id_w]      = 1'b1;
        kick_d              = (pos_q == '0);
      end
      CMD_SEARCH: begin
        if (idx_q != count_q) begin
          if (sel_timer == id_q) begin
            pos_d   = idx_q;
            carry_d = sel_delta;
          end else begin
            idx_d = idx_q + CntW'(1);
          end
        end
      end
      CMD_REMOVE: begin
        for (int j = 0; j < SLOTS - 1; j++) begin
          if (CntW'(j) >= pos_q) begin
            slot_timer_d[j] = slot_timer_q[j+1];
            slot_delta_d[j] = slot_delta_q[j+1];
          end
        end
        count_d        = count_q - CntW'(1);
        active_d[id_w] = 1'b0;
        kick_d         = (pos_q == '0);
      end
      CMD_MERGE: begin
        if (idx_q < count_q) begin
          slot_delta_d[idx_w] = merge_sum[MS_W] ? '1 : merge_sum[MS_W-1:0];
        end
      end
      CMD_DEL_MISS: begin
        active_d[id_w] = 1'b0;
      end
      CMD_TICK: begin
        if (count_q != '0) begin
          if (slot_delta_q[0] > elapsed_q) begin
            slot_delta_d[0] = slot_delta_q[0] - elapsed_q;
          end else begin
            elapsed_d = elapsed_q - slot_delta_q[0];
            who_d     = slot_timer_q[0];
            for (int j = 0; j < SLOTS - 1; j++) begin
              slot_timer_d[j] = slot_timer_q[j+1];
              slot_delta_d[j] = slot_delta_q[j+1];
            end
            count_d          = count_q - CntW'(1);
            active_d[head_w] = 1'b0;
          end
        end
      end
      CMD_EMIT: begin
        if (load) begin
          out_valid_d                = 1'b1;
          out_item_d.kind            = cmd_i.kind;
          out_item_d.expired_id      = cmd_i.use_who ? who_q : id_q;
          out_item_d.kick            = kick_q && !cmd_i.use_who;
          out_item_d.queue_empty     = (count_q == '0);
          out_item_d.next_timeout_ms = (count_q == '0) ? '0 : slot_delta_q[0];
          out_item_d.last            = cmd_i.last;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
      kick_q      <= 1'b0;
    end else begin
      count_q     <= count_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      kick_q      <= kick_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_timer_q <= slot_timer_d;
    slot_delta_q <= slot_delta_d;
    op_q         <= op_d;
    id_q         <= id_d;
    rem_q        <= rem_d;
    elapsed_q    <= elapsed_d;
    idx_q        <= idx_d;
    pos_q        <= pos_d;
    carry_q      <= carry_d;
    who_q        <= who_d;
    out_item_q   <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(SLOTS))
    else $error("queue count exceeds slot capacity");

  a_active_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(active_q) == int'(count_q))
    else $error("active timers disagree with queue count");

  a_insert_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.cmd == CMD_INSERT) |-> (count_q < CntW'(SLOTS)))
    else $error("insert into a full queue");

endmodule

// ----- hw/rtl/delta_list_timer_queue.sv -----
// ----------------------------------------------------------------------------
// Delta-list timer queue
// One-shot timers kept as an ordered list of relative deltas.
//
//   channel  dir  payload      transaction
//   in_i     in   in_item_t    add, delete or tick request
//   out_o    out  out_item_t   expiry or status result
//
// Add walks to the insertion point, inserts and emits; delete searches, removes
// and merges, then emits; tick emits each expired timer, then a done result.
// One list entry is visited per cycle by the walk/search index.
// A new request is taken only when the previous one has put out its last result.
// A stalled result holds in the output register and stalls the controller.
// Reset clears the queue count and active flags; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module delta_list_timer_queue
  import dltq_pkg::*;
#(
  parameter int TIMERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dltq_in_if.sink     in_i,
  dltq_out_if.source  out_o
);

  localparam int Slots = (TIMERS < SLOT_MAX) ? TIMERS : SLOT_MAX;

  dltq_cmd_t    cmd;
  dltq_status_t status;
  logic         in_ready;

  dltq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dltq_datapath #(
    .SLOTS (Slots)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_i.payload),
    .out_ready_i (out_o.ready),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_item_o  (out_o.payload)
  );

  assign in_i.ready = in_ready;

endmodule

// ----- tb/tb_delta_list_timer_queue.sv -----
// ----------------------------------------------------------------------------
// Delta-list timer queue testbench
// Sends add, delete, tick and reserved requests through the request channel and keeps
// its own model of the timer list. Every result transaction is checked field
// by field against the oldest predicted result. Both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_delta_list_timer_queue;
  import dltq_pkg::*;

  localparam int TIMERS       = 16;
  localparam int RANDOM_ITEMS = 400;
  localparam int CALM_ITEMS   = 60;
  localparam int DRAIN_EVERY  = 60;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE       = 40;

  typedef struct {
    in_item_t item;
    bit       drain;
  } request_t;

  logic clk_i;
  logic rst_ni;

  dltq_in_if  req_if ();
  dltq_out_if res_if ();

  delta_list_timer_queue #(
    .TIMERS(TIMERS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (res_if)
  );

  request_t  request_queue[$];
  out_item_t due_results[$];

  logic [ID_W-1:0] list_timer [SLOT_MAX];
  logic [MS_W-1:0] list_delta [SLOT_MAX];
  int              list_len;
  bit              timer_busy [SLOT_MAX];

  int  mismatches;
  int  adds_taken, dels_taken, ticks_taken, others_taken;
  int  results_seen, expiries_seen, rejects_seen, kicks_seen;
  int  gap_left, stall_left, idle_cycles;
  bit  took_req;
  bit  idle_q;
  bit  calm_q;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  task automatic flag_mismatch(input string msg);
    $display("ERROR: %s", msg);
    mismatches++;
  endtask

  function automatic void queue_request(input op_e op, input logic [ID_W-1:0] id,
                                        input logic [MS_W-1:0] timeout,
                                        input logic [MS_W-1:0] elapsed, input bit drain);
    request_t r;
    r.item.operation  = op;
    r.item.timer_id   = id;
    r.item.timeout_ms = timeout;
    r.item.elapsed_ms = elapsed;
    r.drain           = drain;
    request_queue.push_back(r);
  endfunction

  function automatic void add_result(input kind_e kind, input logic [ID_W-1:0] id,
                                     input logic kick, input logic last);
    out_item_t r;
    r.kind            = kind;
    r.expired_id      = id;
    r.kick            = kick;
    r.queue_empty     = (list_len == 0);
    r.next_timeout_ms = (list_len == 0) ? '0 : list_delta[0];
    r.last            = last;
    due_results.push_back(r);
  endfunction

  function automatic void drop_entry(input int pos);
    for (int i = pos; i + 1 < list_len; i++) begin
      list_timer[i] = list_timer[i+1];
      list_delta[i] = list_delta[i+1];
    end
    list_len--;
  endfunction

  function automatic void advance_timer_list(input in_item_t req);
    logic [MS_W-1:0] rem;
    logic [MS_W-1:0] merged;
    logic [ID_W-1:0] who;
    logic [ID_W-1:0] id;
    int              pos;
    bit              found;
    bit              hit;
    id = req.timer_id;
    case (req.operation)
      OP_ADD: begin
        adds_taken++;
        if (id >= TIMERS || timer_busy[id] || req.timeout_ms == '0 ||
            req.timeout_ms == '1 || list_len >= TIMERS) begin
          add_result(KIND_REJECTED, id, 1'b0, 1'b1);
        end else begin
          rem   = req.timeout_ms;
          pos   = list_len;
          found = 1'b0;
          for (int i = 0; i < list_len; i++) begin
            if (!found) begin
              if (rem < list_delta[i]) begin
                list_delta[i] = list_delta[i] - rem;
                pos           = i;
                found         = 1'b1;
              end else begin
                rem = rem - list_delta[i];
              end
            end
          end
          for (int i = list_len; i > pos; i--) begin
            list_timer[i] = list_timer[i-1];
            list_delta[i] = list_delta[i-1];
          end
          list_timer[pos] = id;
          list_delta[pos] = rem;
          list_len++;
          timer_busy[id] = 1'b1;
          add_result(KIND_DONE, id, pos == 0, 1'b1);
        end
      end
      OP_DEL: begin
        dels_taken++;
        hit = 1'b0;
        if (id < TIMERS && timer_busy[id]) begin
          pos   = list_len;
          found = 1'b0;
          for (int i = 0; i < list_len; i++) begin
            if (!found && list_timer[i] == id) begin
              pos   = i;
              found = 1'b1;
            end
          end
          if (found) begin
            if (pos + 1 < list_len) begin
              merged = list_delta[pos+1] + list_delta[pos];
              if (merged < list_delta[pos+1]) merged = '1;
              list_delta[pos+1] = merged;
            end
            hit = (pos == 0);
            drop_entry(pos);
          end
          timer_busy[id] = 1'b0;
        end
        add_result(KIND_DONE, id, hit, 1'b1);
      end
      OP_TICK: begin
        ticks_taken++;
        rem   = req.elapsed_ms;
        found = 1'b0;
        while (list_len > 0 && !found) begin
          if (list_delta[0] > rem) begin
            list_delta[0] = list_delta[0] - rem;
            found         = 1'b1;
          end else begin
            rem = rem - list_delta[0];
            who = list_timer[0];
            drop_entry(0);
            timer_busy[who] = 1'b0;
            add_result(KIND_EXPIRED, who, 1'b0, 1'b0);
          end
        end
        add_result(KIND_DONE, id, 1'b0, 1'b1);
      end
      default: begin
        others_taken++;
        add_result(KIND_REJECTED, id, 1'b0, 1'b1);
      end
    endcase
  endfunction

  task automatic check_result(input out_item_t got);
    out_item_t want;
    results_seen++;
    if (got.kind == KIND_EXPIRED) expiries_seen++;
    if (got.kind == KIND_REJECTED) rejects_seen++;
    if (got.kick) kicks_seen++;
    if (due_results.size() == 0) begin
      flag_mismatch($sformatf("unexpected result kind %0d id %0d", got.kind, got.expired_id));
    end else begin
      want = due_results.pop_front();
      if (got.kind !== want.kind)
        flag_mismatch($sformatf("result %0d kind %0d, want %0d",
                                results_seen, got.kind, want.kind));
      if (got.expired_id !== want.expired_id)
        flag_mismatch($sformatf("result %0d id %0d, want %0d",
                                results_seen, got.expired_id, want.expired_id));
      if (got.kick !== want.kick)
        flag_mismatch($sformatf("result %0d kick %0b, want %0b",
                                results_seen, got.kick, want.kick));
      if (got.queue_empty !== want.queue_empty)
        flag_mismatch($sformatf("result %0d queue_empty %0b, want %0b",
                                results_seen, got.queue_empty, want.queue_empty));
      if (got.next_timeout_ms !== want.next_timeout_ms)
        flag_mismatch($sformatf("result %0d next_timeout_ms %0d, want %0d",
                                results_seen, got.next_timeout_ms, want.next_timeout_ms));
      if (got.last !== want.last)
        flag_mismatch($sformatf("result %0d last %0b, want %0b",
                                results_seen, got.last, want.last));
    end
  endtask

  // Driver: hold the request until taken, then load the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      calm_q         <= 1'b0;
      gap_left        = 0;
    end else begin
      took_req = req_if.valid && req_if.ready;
      if (!req_if.valid || took_req) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (request_queue.size() == 0) begin
          req_if.valid <= 1'b0;
        end else if (request_queue[0].drain && (!idle_q || took_req)) begin
          req_if.valid <= 1'b0;
        end else begin
          req_if.payload <= request_queue[0].item;
          req_if.valid   <= 1'b1;
          void'(request_queue.pop_front());
          if (!calm_q && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 14);
        end
      end
      calm_q <= (request_queue.size() < CALM_ITEMS);
    end
  end

  // Monitor: predict on each request transaction, check each result transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      idle_q       <= 1'b1;
      stall_left    = 0;
    end else begin
      if (req_if.valid && req_if.ready) advance_timer_list(req_if.payload);
      if (res_if.valid && res_if.ready) check_result(res_if.payload);
      idle_q <= (due_results.size() == 0);
      if (calm_q) begin
        res_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    op_e             op;
    logic [ID_W-1:0] id;
    logic [MS_W-1:0] timeout;
    logic [MS_W-1:0] elapsed;
    int              pick;

    list_len   = 0;
    mismatches = 0;
    for (int i = 0; i < SLOT_MAX; i++) timer_busy[i] = 1'b0;

    queue_request(OP_TICK, 4'd5, 32'd0, 32'd0, 1'b0);
    queue_request(OP_ADD, 4'd0, 32'd1, $urandom, 1'b0);
    queue_request(OP_ADD, 4'd15, 32'hFFFF_FFFE, $urandom, 1'b0);
    queue_request(OP_ADD, 4'd0, 32'd50, $urandom, 1'b0);
    queue_request(OP_ADD, 4'd3, 32'd0, $urandom, 1'b0);
    queue_request(OP_ADD, 4'd4, 32'hFFFF_FFFF, $urandom, 1'b0);
    queue_request(OP_ADD, 4'd7, 32'd1, $urandom, 1'b0);
    queue_request(OP_ADD, 4'd8, 32'd100, $urandom, 1'b0);
    queue_request(OP_ADD, 4'd9, 32'd40, $urandom, 1'b0);
    queue_request(OP_DEL, 4'd9, $urandom, $urandom, 1'b0);
    queue_request(OP_DEL, 4'd2, $urandom, $urandom, 1'b0);
    queue_request(OP_RSVD, 4'd10, $urandom, $urandom, 1'b0);
    queue_request(OP_TICK, 4'd12, $urandom, 32'd1, 1'b1);
    queue_request(OP_ADD, 4'd5, 32'd99, $urandom, 1'b0);
    queue_request(OP_TICK, 4'd6, $urandom, 32'd0, 1'b0);
    queue_request(OP_TICK, 4'd11, $urandom, 32'd99, 1'b0);
    queue_request(OP_ADD, 4'd1, 32'd20, $urandom, 1'b0);
    queue_request(OP_ADD, 4'd2, 32'd5, $urandom, 1'b0);
    queue_request(OP_DEL, 4'd2, $urandom, $urandom, 1'b0);
    queue_request(OP_ADD, 4'd6, $urandom_range(1, 32'hFFFF_FFFE), $urandom, 1'b0);
    queue_request(OP_TICK, 4'd14, $urandom, 32'hFFFF_FFFF, 1'b0);
    queue_request(OP_DEL, 4'd15, $urandom, $urandom, 1'b0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      id   = $urandom_range(0, 15);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: timeout = $urandom_range(1, 200);
        6, 7, 8:          timeout = $urandom_range(1, 100000);
        default:          timeout = $urandom;
      endcase
      case ($urandom_range(0, 19))
        0:                    elapsed = 32'd0;
        1, 2:                 elapsed = $urandom;
        3, 4, 5, 6, 7:        elapsed = $urandom_range(0, 300);
        default:              elapsed = $urandom_range(0, 60);
      endcase
      if (pick < 45) begin
        op = OP_ADD;
      end else if (pick < 65) begin
        op = OP_DEL;
      end else if (pick < 95) begin
        op = OP_TICK;
      end else if (pick < 97) begin
        op = OP_RSVD;
      end else begin
        op      = OP_ADD;
        timeout = (pick == 97) ? 32'd0 : 32'hFFFF_FFFF;
      end
      queue_request(op, id, timeout, elapsed, (n % DRAIN_EVERY) == DRAIN_EVERY - 1);
    end

    @(posedge rst_ni);
    while (request_queue.size() != 0 || req_if.valid || due_results.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    while (due_results.size() != 0) begin
      flag_mismatch($sformatf("result kind %0d id %0d never arrived",
                              due_results[0].kind, due_results[0].expired_id));
      void'(due_results.pop_front());
    end

    $display("Requests: %0d add, %0d delete, %0d tick, %0d reserved",
             adds_taken, dels_taken, ticks_taken, others_taken);
    $display("Results: %0d checked, %0d expiries, %0d rejections, %0d kicks, %0d mismatches",
             results_seen, expiries_seen, rejects_seen, kicks_seen, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
